FILE: rtl/core/fmdrw_pkg.sv
// ----------------------------------------------------------------------------
// fmdrw_pkg
// Shared types, codes and CRC / FM helpers for the FM disk channel.
// ----------------------------------------------------------------------------
`default_nettype none

package fmdrw_pkg;

  // item commands
  localparam logic [2:0] FUNC_READ_CELL  = 3'd0;
  localparam logic [2:0] FUNC_WRITE_CELL = 3'd1;
  localparam logic [2:0] FUNC_START_READ = 3'd2;
  localparam logic [2:0] FUNC_START_WR   = 3'd3;
  localparam logic [2:0] FUNC_ABORT      = 3'd4;
  localparam logic [2:0] FUNC_ARM_CRC    = 3'd5;
  localparam logic [2:0] FUNC_CLEAR_CRC  = 3'd6;

  // channel modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_SYNC  = 3'd1;
  localparam logic [2:0] MODE_SYNC2 = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_WRITE = 3'd4;

  // register index of the config port
  localparam logic REG_SYNC_CODE = 1'b0;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_PRESET = 16'hffff;
  localparam logic [7:0]  SYNC_PREFIX = 8'haa;
  localparam logic [15:0] FM_CLOCKS  = 16'haaaa;
  localparam logic [7:0]  SYNC_CODE_RESET = 8'hf5;

  // sector-end cell counts (header, 128-byte and 256-byte sectors)
  localparam logic [15:0] END_HDR  = 16'((4 + 2) * 16);
  localparam logic [15:0] END_S128 = 16'((128 + 2) * 16);
  localparam logic [15:0] END_S256 = 16'((256 + 2) * 16);

  localparam logic [15:0] CNT_RAW_BYTE = 16'd8;
  localparam logic [15:0] CNT_FM_BYTE  = 16'd16;

  typedef logic [15:0] crc_t;

  function automatic crc_t crc_feed(input crc_t crc, input logic bit_in);
    crc_t sh;
    sh = {crc[14:0], 1'b0};
    return (crc[15] ^ bit_in) ? (sh ^ CRC_POLY) : sh;
  endfunction

  // data bit k lands in cell 2k, clock cells are all ones
  function automatic logic [15:0] fm_encode(input logic [7:0] d);
    logic [15:0] raw;
    raw = FM_CLOCKS;
    for (int k = 0; k < 8; k++) begin
      raw[2*k] = d[k];
    end
    return raw;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fm_disk_read_write_channel.sv
// ----------------------------------------------------------------------------
// fm_disk_read_write_channel
// FM floppy bit-cell read/write channel with CRC-16 CCITT.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: func, cell_in,
//   tx_byte, tx_underflow. Each item yields exactly one result item on the
//   output channel (out_valid/out_ready): rx_valid/rx_byte, crc_flag,
//   cell_valid/cell_out, byte_taken and the mode after the item.
//   Results are registered: an item accepted at an edge shows from that edge.
//   Throughput is one item per cycle unless stalled; all per-cell shift, CRC
//   and compare work sits between the input handshake and the result register.
//   in_ready is high whenever the result register is empty or being taken,
//   so a stalled receiver holds the result and blocks only new items.
//   sync_code is written over the APB port (address 0) by the user, only while
//   idle; the block does not enforce it. Reset (rst, synchronous) returns to
//   idle mode, CRC preset, counters clear, sync_code 0xf5, empty result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_disk_read_write_channel (
  input  wire logic        clk,
  input  wire logic        rst,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic        cell_in,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        tx_underflow,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             rx_valid,
  output logic [7:0]       rx_byte,
  output logic             crc_flag,
  output logic             cell_valid,
  output logic             cell_out,
  output logic             byte_taken,
  output logic [2:0]       mode
);
  import fmdrw_pkg::*;

  logic [7:0]  sync_code;
  logic [2:0]  mode_reg,        mode_reg_next;
  logic [15:0] cell_shift,      cell_shift_next;
  logic [7:0]  data_shift,      data_shift_next;
  crc_t        crc_reg,         crc_reg_next;
  logic [15:0] cell_count,      cell_count_next;
  logic        data_phase,      data_phase_next;
  logic        crc_line,        crc_line_next;
  logic        crc_line_prev,   crc_line_prev_next;
  logic [1:0]  underflow_count, underflow_count_next;
  logic [1:0]  crc_bytes_left,  crc_bytes_left_next;

  logic        r_rx_valid, r_cell_valid, r_cell_out, r_taken;
  logic [7:0]  r_rx_byte;

  // one read cell taken
  logic [15:0] tc_shift, tc_count;
  logic [7:0]  tc_data;
  crc_t        tc_crc, sync_crc;
  logic        sync_hit;

  // one write cell driven
  logic [1:0]  wr_uf, wr_cbl;
  crc_t        wr_crc;
  logic [15:0] wr_shift, wr_count;
  logic [7:0]  wr_data, wr_d;
  logic        wr_taken, wr_cell;

  logic accept, cfg_wr;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_SYNC_CODE) ? {24'h0, sync_code} : 32'h0;

  always_comb begin
    tc_shift = {cell_shift[14:0], cell_in};
    tc_count = cell_count + 16'd1;
    tc_data  = data_phase ? {data_shift[6:0], cell_in} : data_shift;
    tc_crc   = data_phase ? crc_feed(crc_reg, cell_in) : crc_reg;
    sync_hit = (tc_shift[7:0] == sync_code) && (tc_shift[15:8] == SYNC_PREFIX);
    // sync byte's data cells are the even ones
    sync_crc = crc_feed(CRC_PRESET, tc_shift[6]);
    sync_crc = crc_feed(sync_crc, tc_shift[4]);
    sync_crc = crc_feed(sync_crc, tc_shift[2]);
    sync_crc = crc_feed(sync_crc, tc_shift[0]);
  end

  always_comb begin
    wr_uf    = underflow_count;
    wr_cbl   = crc_bytes_left;
    wr_crc   = crc_reg;
    wr_shift = cell_shift;
    wr_count = cell_count;
    wr_data  = data_shift;
    wr_d     = tx_byte;
    wr_taken = 1'b0;
    if (cell_count == 16'd0) begin
      wr_taken = 1'b1;
      if (tx_underflow) begin
        wr_uf = 2'd3;
      end else if (underflow_count == 2'd2) begin
        wr_crc = CRC_PRESET;
      end
      if (wr_uf != 2'd0) begin
        // raw sync byte after underflow
        wr_shift = {tx_byte, 8'h00};
        wr_count = CNT_RAW_BYTE;
        wr_uf    = wr_uf - 2'd1;
      end else begin
        if (crc_bytes_left != 2'd0) begin
          wr_d   = wr_crc[15:8];
          wr_cbl = crc_bytes_left - 2'd1;
        end
        wr_data  = wr_d;
        wr_shift = fm_encode(wr_d);
        wr_count = CNT_FM_BYTE;
      end
    end
    wr_cell = wr_shift[15];
    if (wr_count[0]) begin
      wr_crc = crc_feed(wr_crc, wr_cell);
    end
    wr_shift = {wr_shift[14:0], 1'b0};
    wr_count = wr_count - 16'd1;
  end

  always_comb begin
    mode_reg_next        = mode_reg;
    cell_shift_next      = cell_shift;
    data_shift_next      = data_shift;
    crc_reg_next         = crc_reg;
    cell_count_next      = cell_count;
    data_phase_next      = data_phase;
    crc_line_next        = crc_line;
    crc_line_prev_next   = crc_line_prev;
    underflow_count_next = underflow_count;
    crc_bytes_left_next  = crc_bytes_left;
    r_rx_valid   = 1'b0;
    r_rx_byte    = 8'h00;
    r_cell_valid = 1'b0;
    r_cell_out   = 1'b0;
    r_taken      = 1'b0;
    case (func)
      FUNC_READ_CELL: begin
        if (mode_reg == MODE_SYNC || mode_reg == MODE_SYNC2 || mode_reg == MODE_READ) begin
          cell_shift_next = tc_shift;
          cell_count_next = tc_count;
          data_shift_next = tc_data;
          crc_reg_next    = tc_crc;
          data_phase_next = ~data_phase;
        end
        if (mode_reg == MODE_SYNC) begin
          if (sync_hit) begin
            crc_reg_next    = sync_crc;
            data_phase_next = 1'b0;
            cell_count_next = 16'd0;
            r_rx_valid      = 1'b1;
            r_rx_byte       = tc_shift[7:0];
            mode_reg_next   = MODE_SYNC2;
          end
        end else if (mode_reg == MODE_SYNC2) begin
          if (tc_count == CNT_RAW_BYTE) begin
            r_rx_valid      = 1'b1;
            r_rx_byte       = tc_shift[7:0];
            cell_count_next = 16'd0;
            mode_reg_next   = MODE_READ;
          end
        end else if (mode_reg == MODE_READ) begin
          if (tc_count[3:0] == 4'd0) begin
            r_rx_valid         = 1'b1;
            r_rx_byte          = tc_data;
            crc_line_prev_next = (tc_crc != 16'h0000);
            // sector end: status shows without the byte delay
            if (tc_count == END_HDR || tc_count == END_S128 || tc_count == END_S256) begin
              crc_line_next = crc_line_prev_next;
            end else begin
              crc_line_next = crc_line_prev;
            end
          end
        end
      end
      FUNC_WRITE_CELL: begin
        if (mode_reg == MODE_WRITE) begin
          underflow_count_next = wr_uf;
          crc_bytes_left_next  = wr_cbl;
          crc_reg_next         = wr_crc;
          cell_shift_next      = wr_shift;
          cell_count_next      = wr_count;
          data_shift_next      = wr_data;
          r_cell_valid         = 1'b1;
          r_cell_out           = wr_cell;
          r_taken              = wr_taken;
        end
      end
      FUNC_START_READ, FUNC_START_WR: begin
        mode_reg_next   = (func == FUNC_START_READ) ? MODE_SYNC : MODE_WRITE;
        cell_shift_next = 16'h0000;
        crc_reg_next    = CRC_PRESET;
        cell_count_next = 16'h0000;
        data_phase_next = 1'b0;
        data_shift_next = 8'h00;
        if (func == FUNC_START_WR) begin
          underflow_count_next = 2'd0;
        end
      end
      FUNC_ABORT: begin
        mode_reg_next = MODE_IDLE;
      end
      FUNC_ARM_CRC: begin
        crc_bytes_left_next = 2'd2;
      end
      FUNC_CLEAR_CRC: begin
        crc_bytes_left_next = 2'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_code       <= SYNC_CODE_RESET;
    end else if (cfg_wr && paddr[2] == REG_SYNC_CODE) begin
      sync_code       <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_IDLE;
      cell_shift      <= 16'h0000;
      data_shift      <= 8'h00;
      crc_reg         <= CRC_PRESET;
      cell_count      <= 16'h0000;
      data_phase      <= 1'b0;
      crc_line        <= 1'b0;
      crc_line_prev   <= 1'b0;
      underflow_count <= 2'd0;
      crc_bytes_left  <= 2'd0;
    end else if (accept) begin
      mode_reg        <= mode_reg_next;
      cell_shift      <= cell_shift_next;
      data_shift      <= data_shift_next;
      crc_reg         <= crc_reg_next;
      cell_count      <= cell_count_next;
      data_phase      <= data_phase_next;
      crc_line        <= crc_line_next;
      crc_line_prev   <= crc_line_prev_next;
      underflow_count <= underflow_count_next;
      crc_bytes_left  <= crc_bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rx_valid   <= r_rx_valid;
      rx_byte    <= r_rx_byte;
      crc_flag   <= crc_line_next;
      cell_valid <= r_cell_valid;
      cell_out   <= r_cell_out;
      byte_taken <= r_taken;
      mode       <= mode_reg_next;
    end
  end

  // result register tracks the state left after its item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_valid |-> mode == MODE_WRITE && !rx_valid)
    else $error("write cell result outside write mode");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_valid |-> mode == MODE_SYNC2 || mode == MODE_READ)
    else $error("received byte outside read modes");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_taken |-> cell_valid)
    else $error("byte taken without a write cell");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && mode == $past(mode_reg_next) && mode_reg == mode)
    else $error("result mode differs from channel mode");

endmodule

`default_nettype wire

FILE: verif/tb_fm_disk_read_write_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fm_disk_read_write_channel
// Self-checking bench for the FM disk channel. Drives read sectors built from
// FM-encoded bytes with sync marks and CRCs, write sectors with underflow
// syncs and CRC substitution, and random command noise. One header-sized
// sector runs with no idling on either side. Every result item is checked
// against an in-bench channel predictor.
// ----------------------------------------------------------------------------

module tb_fm_disk_read_write_channel;
  import fmdrw_pkg::*;

  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  localparam int IDLE_PCT = 31;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 200;
  // reaches the header sector end, run back to back
  localparam int QUIET_SECTOR_BYTES = 6;
  localparam int BLOCK_ITEMS = 125;

  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       crc_flag;
    logic       cell_valid;
    logic       cell_out;
    logic       byte_taken;
    logic [2:0] mode;
  } chan_result_t;

  class fm_channel_scoreboard;
    logic [7:0]  sync_code;
    logic [2:0]  mode;
    logic [15:0] cell_sr;
    logic [7:0]  data_sr;
    logic [15:0] crc;
    logic [15:0] cell_count;
    logic        data_phase;
    logic        crc_line;
    logic        crc_line_prev;
    logic [1:0]  underflow_left;
    logic [1:0]  crc_bytes_left;
    chan_result_t due_outputs[$];
    int mismatches;

    function new();
      sync_code = SYNC_CODE_RESET;
      mode = MODE_IDLE;
      cell_sr = '0;
      data_sr = '0;
      crc = CRC_PRESET;
      cell_count = '0;
      data_phase = 1'b0;
      crc_line = 1'b0;
      crc_line_prev = 1'b0;
      underflow_left = '0;
      crc_bytes_left = '0;
      mismatches = 0;
    endfunction

    static function logic [15:0] crc_shift(logic [15:0] c, logic b);
      logic [15:0] sh;
      sh = {c[14:0], 1'b0};
      return (c[15] ^ b) ? (sh ^ CRC_POLY) : sh;
    endfunction

    // clock cell always set, data cell follows it
    function logic [15:0] fm_cells(logic [7:0] d);
      logic [15:0] raw;
      for (int i = 0; i < 8; i++) raw[15 - 2 * i -: 2] = {1'b1, d[7 - i]};
      return raw;
    endfunction

    function void take_cell(logic b);
      cell_sr = {cell_sr[14:0], b};
      cell_count = cell_count + 16'd1;
      if (data_phase) begin
        data_sr = {data_sr[6:0], b};
        crc = crc_shift(crc, b);
      end
      data_phase = ~data_phase;
    endfunction

    function void restart(logic [2:0] m);
      mode = m;
      cell_sr = '0;
      crc = CRC_PRESET;
      cell_count = '0;
      data_phase = 1'b0;
      data_sr = '0;
    endfunction

    // returns 1 when the item did something
    function bit note_item(logic [2:0] f, logic cin, logic [7:0] tx, logic tuf);
      chan_result_t r;
      logic [7:0] d;
      bit acted;
      r = '0;
      acted = 1'b1;
      case (f)
        FUNC_READ_CELL: begin
          if (mode == MODE_SYNC) begin
            take_cell(cin);
            if (cell_sr[7:0] == sync_code && cell_sr[15:8] == SYNC_PREFIX) begin
              crc = CRC_PRESET;
              data_phase = 1'b0;
              cell_count = '0;
              for (int i = 6; i >= 0; i -= 2) crc = crc_shift(crc, cell_sr[i]);
              r.rx_valid = 1'b1;
              r.rx_byte = cell_sr[7:0];
              mode = MODE_SYNC2;
            end
          end else if (mode == MODE_SYNC2) begin
            take_cell(cin);
            if (cell_count == CNT_RAW_BYTE) begin
              r.rx_valid = 1'b1;
              r.rx_byte = cell_sr[7:0];
              cell_count = '0;
              mode = MODE_READ;
            end
          end else if (mode == MODE_READ) begin
            take_cell(cin);
            if (cell_count[3:0] == 4'd0) begin
              r.rx_valid = 1'b1;
              r.rx_byte = data_sr;
              crc_line = crc_line_prev;
              crc_line_prev = (crc != 16'd0);
              // at a sector end the fresh status shows without the delay
              if (cell_count == END_HDR || cell_count == END_S128 ||
                  cell_count == END_S256)
                crc_line = crc_line_prev;
            end
          end else begin
            acted = 1'b0;
          end
        end
        FUNC_WRITE_CELL: begin
          if (mode == MODE_WRITE) begin
            if (cell_count == 16'd0) begin
              d = tx;
              r.byte_taken = 1'b1;
              if (tuf) underflow_left = 2'd3;
              else if (underflow_left == 2'd2) crc = CRC_PRESET;
              if (underflow_left != 2'd0) begin
                cell_sr = {d, 8'h00};
                cell_count = CNT_RAW_BYTE;
                underflow_left = underflow_left - 2'd1;
              end else begin
                if (crc_bytes_left != 2'd0) begin
                  d = crc[15:8];
                  crc_bytes_left = crc_bytes_left - 2'd1;
                end
                data_sr = d;
                cell_sr = fm_cells(d);
                cell_count = CNT_FM_BYTE;
              end
            end
            r.cell_valid = 1'b1;
            r.cell_out = cell_sr[15];
            if (cell_count[0]) crc = crc_shift(crc, cell_sr[15]);
            cell_sr = {cell_sr[14:0], 1'b0};
            cell_count = cell_count - 16'd1;
          end else begin
            acted = 1'b0;
          end
        end
        FUNC_START_READ: restart(MODE_SYNC);
        FUNC_START_WR: begin
          underflow_left = '0;
          restart(MODE_WRITE);
        end
        FUNC_ABORT: mode = MODE_IDLE;
        FUNC_ARM_CRC: crc_bytes_left = 2'd2;
        FUNC_CLEAR_CRC: crc_bytes_left = 2'd0;
        default: acted = 1'b0;
      endcase
      r.crc_flag = crc_line;
      r.mode = mode;
      due_outputs.push_back(r);
      return acted;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %0s mismatch, expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(chan_result_t got);
      chan_result_t want;
      if (due_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result item with none pending: %h", $time, got);
        return;
      end
      want = due_outputs.pop_front();
      compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("crc_flag", 8'(want.crc_flag), 8'(got.crc_flag));
      compare_field("cell_valid", 8'(want.cell_valid), 8'(got.cell_valid));
      compare_field("cell_out", 8'(want.cell_out), 8'(got.cell_out));
      compare_field("byte_taken", 8'(want.byte_taken), 8'(got.byte_taken));
      compare_field("mode", 8'(want.mode), 8'(got.mode));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = FUNC_ABORT;
  logic        cell_in = 1'b0;
  logic [7:0]  tx_byte = '0;
  logic        tx_underflow = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        rx_valid;
  logic [7:0]  rx_byte;
  logic        crc_flag;
  logic        cell_valid;
  logic        cell_out;
  logic        byte_taken;
  logic [2:0]  mode;

  fm_channel_scoreboard sb;
  logic [7:0] sync_setting = SYNC_CODE_RESET;
  bit quiet = 1'b0;
  int hold_len = 0;
  int items_done = 0;
  int cycle_count = 0;
  int rd_cells = 0;
  int rd_flip = -1;

  fm_disk_read_write_channel u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .cell_in(cell_in),
    .tx_byte(tx_byte), .tx_underflow(tx_underflow),
    .out_valid(out_valid), .out_ready(out_ready), .rx_valid(rx_valid),
    .rx_byte(rx_byte), .crc_flag(crc_flag), .cell_valid(cell_valid),
    .cell_out(cell_out), .byte_taken(byte_taken), .mode(mode)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(chan_result_t'({rx_valid, rx_byte, crc_flag, cell_valid,
                                      cell_out, byte_taken, mode}));
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_item(logic [2:0] f, logic cin, logic [7:0] tx, logic tuf);
    // each draw under IDLE_PCT holds in_valid low, keeping the idle share near IDLE_PCT
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    cell_in <= cin;
    tx_byte <= tx;
    tx_underflow <= tuf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(sb.note_item(f, cin, tx, tuf));
    items_done++;
  endtask

  task automatic send_cmd(logic [2:0] f);
    send_item(f, 1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic set_sync_code(logic [7:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_SYNC_CODE, 2'b00};
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.sync_code = v;
  endtask

  // read cell, with one optional flipped cell per sector
  task automatic emit_cell(logic b);
    send_item(FUNC_READ_CELL, b ^ (rd_cells == rd_flip), 8'($urandom_range(255)),
              1'($urandom_range(1)));
    rd_cells++;
  endtask

  task automatic emit_raw(logic [7:0] v);
    for (int i = 7; i >= 0; i--) emit_cell(v[i]);
  endtask

  task automatic emit_fm(logic [7:0] d);
    for (int i = 7; i >= 0; i--) begin
      emit_cell(1'b1);
      emit_cell(d[i]);
    end
  endtask

  // raw bytes only carry data in bits 6, 4, 2, 0
  function automatic logic [15:0] crc_over(logic [15:0] c, logic [7:0] v, bit raw);
    for (int i = 7; i >= 0; i--)
      if (!raw || i % 2 == 0) c = fm_channel_scoreboard::crc_shift(c, v[i]);
    return c;
  endfunction

  function automatic bit is_sector_end(int cells);
    return cells == int'(END_HDR) || cells == int'(END_S128) || cells == int'(END_S256);
  endfunction

  // preamble, 0xaa + sync, second raw byte, data with CRC placed at sector ends
  task automatic read_sector(int nbytes, bit corrupt);
    logic [15:0] crc_run;
    logic [15:0] crc_hold;
    logic [7:0]  d;
    logic [7:0]  mark2;
    rd_cells = 0;
    rd_flip = corrupt ? $urandom_range(16 * nbytes + 40) : -1;
    send_cmd(FUNC_START_READ);
    repeat ($urandom_range(2)) emit_fm(8'h00);
    emit_raw(SYNC_PREFIX);
    emit_raw(sync_setting);
    mark2 = 8'($urandom_range(255));
    emit_raw(mark2);
    crc_run = crc_over(crc_over(CRC_PRESET, sync_setting, 1'b1), mark2, 1'b1);
    crc_hold = crc_run;
    for (int b = 0; b < nbytes; b++) begin
      if (is_sector_end(16 * (b + 2))) begin
        crc_hold = crc_run;
        d = crc_hold[15:8];
      end else if (is_sector_end(16 * (b + 1))) begin
        d = crc_hold[7:0];
      end else begin
        d = 8'($urandom_range(255));
      end
      emit_fm(d);
      crc_run = crc_over(crc_run, d, 1'b0);
    end
    rd_flip = -1;
    if ($urandom_range(1)) send_cmd(FUNC_ABORT);
  endtask

  // keeps tx fields steady until the block has sent the whole byte
  task automatic write_byte(logic [7:0] tx, logic tuf);
    do begin
      send_item(FUNC_WRITE_CELL, 1'($urandom_range(1)), tx, tuf);
      if ($urandom_range(99) < 3)
        send_cmd($urandom_range(1) ? FUNC_ARM_CRC : FUNC_CLEAR_CRC);
    end while (sb.mode == MODE_WRITE && sb.cell_count != 16'd0);
  endtask

  task automatic write_sector();
    if ($urandom_range(3) == 0) send_cmd(FUNC_CLEAR_CRC);
    send_cmd(FUNC_START_WR);
    // an underflow turns the underflowing byte and the next two bytes into raw sync bytes
    if ($urandom_range(1)) write_byte(8'($urandom_range(255)), 1'b1);
    repeat ($urandom_range(1, 5))
      write_byte(8'($urandom_range(255)), $urandom_range(99) < 5);
    if ($urandom_range(9) < 7) begin
      send_cmd(FUNC_ARM_CRC);
      repeat (2) write_byte(8'($urandom_range(255)), 1'b0);
    end
    if ($urandom_range(1)) send_cmd(FUNC_ABORT);
  endtask

  task automatic emit_noise();
    repeat ($urandom_range(5, 20))
      send_item(3'($urandom_range(7)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                1'($urandom_range(1)));
  endtask

  task automatic random_block(int count);
    int target;
    int pick;
    target = items_done + count;
    while (items_done < target) begin
      pick = $urandom_range(99);
      if (pick < 40)
        read_sector(($urandom_range(9) < 4) ? 6 : $urandom_range(1, 4), $urandom_range(99) < 15);
      else if (pick < 75)
        write_sector();
      else
        emit_noise();
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // commands out of place while idle
    send_item(FUNC_READ_CELL, 1'b1, 8'hff, 1'b1);
    send_item(FUNC_WRITE_CELL, 1'b0, 8'h00, 1'b0);
    send_item(FUNC_UNUSED, 1'b1, 8'hff, 1'b1);
    send_cmd(FUNC_ARM_CRC);
    send_cmd(FUNC_CLEAR_CRC);
    send_cmd(FUNC_ABORT);
    // write: cells of an underflow byte, CRC arming, then a read cell in write mode
    send_cmd(FUNC_START_WR);
    send_item(FUNC_WRITE_CELL, 1'b1, 8'hff, 1'b1);
    repeat (3) send_item(FUNC_WRITE_CELL, 1'b0, 8'h00, 1'b0);
    send_cmd(FUNC_ARM_CRC);
    send_item(FUNC_READ_CELL, 1'b1, 8'h5a, 1'b0);
    // read: cells both ways, then a write cell during sync search
    send_cmd(FUNC_START_READ);
    send_item(FUNC_READ_CELL, 1'b0, 8'h00, 1'b0);
    send_item(FUNC_READ_CELL, 1'b1, 8'hff, 1'b1);
    send_item(FUNC_WRITE_CELL, 1'b1, 8'hff, 1'b0);
    send_cmd(FUNC_START_WR);
    send_item(FUNC_WRITE_CELL, 1'b0, 8'h00, 1'b0);
    send_cmd(FUNC_ABORT);

    for (int p = 0; p < 4; p++) begin
      wait_results_done();
      case (p)
        0: sync_setting = 8'h00;
        1: sync_setting = 8'hff;
        2: sync_setting = SYNC_CODE_RESET;
        default: sync_setting = 8'($urandom_range(255));
      endcase
      set_sync_code(sync_setting);
      if (p == 1) hold_len = HOLD_CYCLES;
      if (p == 2) begin
        quiet = 1'b1;
        read_sector(QUIET_SECTOR_BYTES, 1'b0);
        quiet = 1'b0;
      end
      random_block(BLOCK_ITEMS);
    end

    wait_results_done();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_outputs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/fmdrw_pkg.sv
rtl/core/fm_disk_read_write_channel.sv
verif/tb_fm_disk_read_write_channel.sv
